[design/acm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers of the angle-to-cursor mapper.
// Used by every module of the block; depends on nothing.
package acm_pkg;

   localparam int YAW_W       = 9;
   localparam int PITCH_W     = 9;
   localparam int SPAN_W      = 14;
   localparam int MARGIN_W    = 12;
   localparam int POS_W       = 16;
   localparam int EXT_W       = 10;
   localparam int NUM_W       = 25;
   localparam int MAG_W       = 24;
   localparam int REM_W       = 9;
   localparam int STEP_W      = REM_W + MAG_W;
   localparam int DIV_STEPS   = 24;
   localparam int CNT_W       = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int ANG_HALF      = 180;
   localparam int ANG_FULL      = 360;
   localparam int SPAN_X_RESET  = 1820;
   localparam int SPAN_Y_RESET  = 980;
   localparam int MARGIN_RESET  = 50;
   localparam int POS_MAX       = 32767;
   localparam int POS_MIN       = -32768;

   typedef enum logic [2:0] {
      KIND_START,
      KIND_CORNER_A,
      KIND_CORNER_B,
      KIND_MOVE,
      KIND_END
   } kind_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_PRESS,
      ACT_RELEASE
   } act_type;

   typedef enum logic [1:0] {
      CSR_SPAN_X,
      CSR_SPAN_Y,
      CSR_MARGIN_X,
      CSR_MARGIN_Y
   } csr_index_type;

   typedef struct packed {
      logic [2:0]                kind;
      logic [YAW_W-1:0]          yaw;
      logic signed [PITCH_W-1:0] pitch;
      logic                      left_button;
      logic                      right_button;
   } item_type;

   typedef struct packed {
      logic [SPAN_W-1:0]   span_x;
      logic [SPAN_W-1:0]   span_y;
      logic [MARGIN_W-1:0] margin_x;
      logic [MARGIN_W-1:0] margin_y;
   } cfg_type;

   typedef struct packed {
      logic                    pos_valid;
      logic signed [NUM_W-1:0] num_x;
      logic signed [NUM_W-1:0] num_y;
      logic signed [EXT_W-1:0] den_x;
      logic signed [EXT_W-1:0] den_y;
      act_type                 left_action;
      act_type                 right_action;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   function automatic logic [YAW_W-1:0] wrap_yaw(input logic [YAW_W-1:0] v);
      logic [YAW_W:0] s;
      s = {1'b0, v} + (YAW_W+1)'(ANG_HALF);
      if (s >= (YAW_W+1)'(ANG_FULL)) begin
         s = s - (YAW_W+1)'(ANG_FULL);
      end
      return s[YAW_W-1:0];
   endfunction

endpackage

[design/acm_front.sv]
`timescale 1ns / 1ps
// Front end: accepts requests, updates calibration and button state, and
// queues one division job per request. Depends on acm_pkg.
module acm_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  acm_pkg::item_type       item,
   input  acm_pkg::cfg_type        cfg,
   input  acm_pkg::queue_stat_type qstat,
   output logic                    push,
   output acm_pkg::job_type        job
);

   typedef enum logic [1:0] {F_IDLE, F_UPD, F_JOB} fstate_type;

   fstate_type state_ff, state_in;
   acm_pkg::item_type item_ff, item_in;
   logic [acm_pkg::YAW_W-1:0] a_yaw_ff, a_yaw_in, b_yaw_ff, b_yaw_in, cur_yaw_ff, cur_yaw_in;
   logic signed [acm_pkg::PITCH_W-1:0] a_pitch_ff, a_pitch_in, b_pitch_ff, b_pitch_in;
   logic signed [acm_pkg::PITCH_W-1:0] cur_pitch_ff, cur_pitch_in;
   logic known_a_ff, known_a_in, known_b_ff, known_b_in, wrap_ff, wrap_in;
   logic prev_l_ff, prev_l_in, prev_r_ff, prev_r_in;
   logic calc_ff, calc_in;
   acm_pkg::act_type la_ff, la_in, ra_ff, ra_in;

   logic signed [acm_pkg::EXT_W-1:0] ex, ey, dx, dy;

   function automatic acm_pkg::act_type button_edge(input logic now, input logic last);
      if (now && !last) begin
         return acm_pkg::ACT_PRESS;
      end
      if (!now && last) begin
         return acm_pkg::ACT_RELEASE;
      end
      return acm_pkg::ACT_NONE;
   endfunction

   always_comb begin
      logic [acm_pkg::YAW_W-1:0] yaw_w;
      logic signed [acm_pkg::EXT_W-1:0] diff;
      logic recheck;
      state_in     = state_ff;
      item_in      = item_ff;
      a_yaw_in     = a_yaw_ff;
      b_yaw_in     = b_yaw_ff;
      cur_yaw_in   = cur_yaw_ff;
      a_pitch_in   = a_pitch_ff;
      b_pitch_in   = b_pitch_ff;
      cur_pitch_in = cur_pitch_ff;
      known_a_in   = known_a_ff;
      known_b_in   = known_b_ff;
      wrap_in      = wrap_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      calc_in      = calc_ff;
      la_in        = la_ff;
      ra_in        = ra_ff;
      recheck      = 1'b0;
      yaw_w        = wrap_ff ? acm_pkg::wrap_yaw(item_ff.yaw) : item_ff.yaw;
      diff         = '0;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               item_in  = item;
               state_in = F_UPD;
            end
         end
         F_UPD: begin
            calc_in  = 1'b0;
            la_in    = acm_pkg::ACT_NONE;
            ra_in    = acm_pkg::ACT_NONE;
            state_in = F_JOB;
            case (acm_pkg::kind_type'(item_ff.kind))
               acm_pkg::KIND_START: begin
                  known_a_in = 1'b0;
                  known_b_in = 1'b0;
                  wrap_in    = 1'b0;
               end
               acm_pkg::KIND_CORNER_A: begin
                  a_yaw_in     = yaw_w;
                  a_pitch_in   = item_ff.pitch;
                  cur_yaw_in   = yaw_w;
                  cur_pitch_in = item_ff.pitch;
                  known_a_in   = 1'b1;
                  recheck      = 1'b1;
                  calc_in      = 1'b1;
               end
               acm_pkg::KIND_CORNER_B: begin
                  b_yaw_in     = yaw_w;
                  b_pitch_in   = item_ff.pitch;
                  cur_yaw_in   = yaw_w;
                  cur_pitch_in = item_ff.pitch;
                  known_b_in   = 1'b1;
                  recheck      = 1'b1;
                  calc_in      = 1'b1;
               end
               acm_pkg::KIND_MOVE: begin
                  cur_yaw_in   = yaw_w;
                  cur_pitch_in = item_ff.pitch;
                  calc_in      = 1'b1;
                  la_in        = button_edge(item_ff.left_button, prev_l_ff);
                  ra_in        = button_edge(item_ff.right_button, prev_r_ff);
                  prev_l_in    = item_ff.left_button;
                  prev_r_in    = item_ff.right_button;
               end
               default: begin
               end
            endcase
            if (recheck) begin
               diff = $signed({1'b0, a_yaw_in}) - $signed({1'b0, b_yaw_in});
               if ((diff > acm_pkg::EXT_W'(acm_pkg::ANG_HALF) ||
                    diff < -acm_pkg::EXT_W'(acm_pkg::ANG_HALF)) && known_a_in && known_b_in) begin
                  wrap_in    = 1'b1;
                  a_yaw_in   = acm_pkg::wrap_yaw(a_yaw_in);
                  b_yaw_in   = acm_pkg::wrap_yaw(b_yaw_in);
                  cur_yaw_in = acm_pkg::wrap_yaw(cur_yaw_in);
               end else begin
                  wrap_in = 1'b0;
               end
            end
         end
         F_JOB: begin
            if (!qstat.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         a_yaw_ff     <= '0;
         b_yaw_ff     <= '0;
         cur_yaw_ff   <= '0;
         a_pitch_ff   <= '0;
         b_pitch_ff   <= '0;
         cur_pitch_ff <= '0;
         known_a_ff   <= 1'b0;
         known_b_ff   <= 1'b0;
         wrap_ff      <= 1'b0;
         prev_l_ff    <= 1'b0;
         prev_r_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_yaw_ff     <= a_yaw_in;
         b_yaw_ff     <= b_yaw_in;
         cur_yaw_ff   <= cur_yaw_in;
         a_pitch_ff   <= a_pitch_in;
         b_pitch_ff   <= b_pitch_in;
         cur_pitch_ff <= cur_pitch_in;
         known_a_ff   <= known_a_in;
         known_b_ff   <= known_b_in;
         wrap_ff      <= wrap_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
      end
      item_ff <= item_in;
      calc_ff <= calc_in;
      la_ff   <= la_in;
      ra_ff   <= ra_in;
   end

   assign ex = $signed({1'b0, b_yaw_ff}) - $signed({1'b0, a_yaw_ff});
   assign ey = $signed({b_pitch_ff[acm_pkg::PITCH_W-1], b_pitch_ff})
             - $signed({a_pitch_ff[acm_pkg::PITCH_W-1], a_pitch_ff});
   assign dx = $signed({1'b0, cur_yaw_ff}) - $signed({1'b0, a_yaw_ff});
   assign dy = $signed({cur_pitch_ff[acm_pkg::PITCH_W-1], cur_pitch_ff})
             - $signed({a_pitch_ff[acm_pkg::PITCH_W-1], a_pitch_ff});

   assign req_ready = (state_ff == F_IDLE);
   assign push      = (state_ff == F_JOB) && !qstat.full;

   always_comb begin
      job.pos_valid    = calc_ff && known_a_ff && known_b_ff && (ex != '0) && (ey != '0);
      job.num_x        = acm_pkg::NUM_W'($signed({1'b0, cfg.span_x})) * acm_pkg::NUM_W'(dx);
      job.num_y        = acm_pkg::NUM_W'($signed({1'b0, cfg.span_y})) * acm_pkg::NUM_W'(dy);
      job.den_x        = ex;
      job.den_y        = ey;
      job.left_action  = la_ff;
      job.right_action = ra_ff;
   end

endmodule

[design/acm_queue.sv]
`timescale 1ns / 1ps
// Short job queue between front and back end.
// Depends on acm_pkg for the job type and depth.
module acm_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  acm_pkg::job_type        push_job,
   input  logic                    pop,
   output acm_pkg::job_type        pop_job,
   output acm_pkg::queue_stat_type qstat
);

   acm_pkg::job_type entry_ff [acm_pkg::QUEUE_DEPTH];
   logic [acm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [acm_pkg::QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (acm_pkg::QPTR_W+1)'(push) - (acm_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job     = entry_ff[rd_ptr_ff];
   assign qstat.full  = (count_ff == (acm_pkg::QPTR_W+1)'(acm_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

[design/acm_back.sv]
`timescale 1ns / 1ps
// Back end: two-lane restoring divider, margin add, saturation and the
// response register. Depends on acm_pkg.
module acm_back (
   input  logic                           clock,
   input  logic                           reset,
   input  acm_pkg::queue_stat_type        qstat,
   input  acm_pkg::job_type               job,
   output logic                           pop,
   input  acm_pkg::cfg_type               cfg,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           pos_valid,
   output logic signed [acm_pkg::POS_W-1:0] screen_x,
   output logic signed [acm_pkg::POS_W-1:0] screen_y,
   output acm_pkg::act_type               left_action,
   output acm_pkg::act_type               right_action
);

   typedef enum logic [1:0] {B_IDLE, B_DIV, B_OUT} bstate_type;

   bstate_type state_ff, state_in;
   logic [acm_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [acm_pkg::MAG_W-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [acm_pkg::REM_W-1:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [acm_pkg::REM_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic negx_ff, negx_in, negy_ff, negy_in;
   logic val_ff, val_in;
   acm_pkg::act_type la_ff, la_in, ra_ff, ra_in;
   logic out_valid_ff, out_valid_in, out_pos_ff, out_pos_in;
   logic signed [acm_pkg::POS_W-1:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   acm_pkg::act_type out_la_ff, out_la_in, out_ra_ff, out_ra_in;
   logic [acm_pkg::STEP_W-1:0] step_x, step_y;

   function automatic logic [acm_pkg::MAG_W-1:0] mag_num(
      input logic signed [acm_pkg::NUM_W-1:0] v);
      logic [acm_pkg::NUM_W-1:0] m;
      m = v[acm_pkg::NUM_W-1] ? acm_pkg::NUM_W'(-v) : acm_pkg::NUM_W'(v);
      return m[acm_pkg::MAG_W-1:0];
   endfunction

   function automatic logic [acm_pkg::REM_W-1:0] mag_den(
      input logic signed [acm_pkg::EXT_W-1:0] v);
      logic [acm_pkg::EXT_W-1:0] m;
      m = v[acm_pkg::EXT_W-1] ? acm_pkg::EXT_W'(-v) : acm_pkg::EXT_W'(v);
      return m[acm_pkg::REM_W-1:0];
   endfunction

   function automatic logic [acm_pkg::STEP_W-1:0] div_step(
      input logic [acm_pkg::REM_W-1:0] r,
      input logic [acm_pkg::MAG_W-1:0] q,
      input logic [acm_pkg::REM_W-1:0] d);
      logic [acm_pkg::REM_W:0] cat;
      logic [acm_pkg::REM_W:0] dif;
      logic ge;
      cat = {r, q[acm_pkg::MAG_W-1]};
      dif = cat - {1'b0, d};
      ge  = (cat >= {1'b0, d});
      return {ge ? dif[acm_pkg::REM_W-1:0] : cat[acm_pkg::REM_W-1:0],
              q[acm_pkg::MAG_W-2:0], ge};
   endfunction

   function automatic logic signed [acm_pkg::POS_W-1:0] finish(
      input logic [acm_pkg::MAG_W-1:0] q, input logic neg,
      input logic [acm_pkg::MARGIN_W-1:0] margin);
      logic signed [acm_pkg::MAG_W+1:0] qs;
      logic signed [acm_pkg::MAG_W+1:0] sum;
      qs  = $signed({2'b00, q});
      qs  = neg ? -qs : qs;
      sum = qs + $signed({(acm_pkg::MAG_W+2-acm_pkg::MARGIN_W)'(0), margin});
      if (sum > (acm_pkg::MAG_W+2)'(acm_pkg::POS_MAX)) begin
         return acm_pkg::POS_W'(acm_pkg::POS_MAX);
      end
      if (sum < $signed((acm_pkg::MAG_W+2)'(acm_pkg::POS_MIN))) begin
         return acm_pkg::POS_W'(acm_pkg::POS_MIN);
      end
      return sum[acm_pkg::POS_W-1:0];
   endfunction

   assign step_x = div_step(rx_ff, qx_ff, dx_ff);
   assign step_y = div_step(ry_ff, qy_ff, dy_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      negx_in      = negx_ff;
      negy_in      = negy_ff;
      val_in       = val_ff;
      la_in        = la_ff;
      ra_in        = ra_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_pos_in   = out_pos_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_la_in    = out_la_ff;
      out_ra_in    = out_ra_ff;
      pop          = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               qx_in    = mag_num(job.num_x);
               qy_in    = mag_num(job.num_y);
               rx_in    = '0;
               ry_in    = '0;
               dx_in    = mag_den(job.den_x);
               dy_in    = mag_den(job.den_y);
               negx_in  = job.num_x[acm_pkg::NUM_W-1] ^ job.den_x[acm_pkg::EXT_W-1];
               negy_in  = job.num_y[acm_pkg::NUM_W-1] ^ job.den_y[acm_pkg::EXT_W-1];
               val_in   = job.pos_valid;
               la_in    = job.left_action;
               ra_in    = job.right_action;
               cnt_in   = '0;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            {rx_in, qx_in} = step_x;
            {ry_in, qy_in} = step_y;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == acm_pkg::CNT_W'(acm_pkg::DIV_STEPS - 1)) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!out_valid_ff || rsp_ready) begin
               out_valid_in = 1'b1;
               out_pos_in   = val_ff;
               out_x_in     = val_ff ? finish(qx_ff, negx_ff, cfg.margin_x) : '0;
               out_y_in     = val_ff ? finish(qy_ff, negy_ff, cfg.margin_y) : '0;
               out_la_in    = la_ff;
               out_ra_in    = ra_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cnt_ff    <= cnt_in;
      qx_ff     <= qx_in;
      qy_ff     <= qy_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      negx_ff   <= negx_in;
      negy_ff   <= negy_in;
      val_ff    <= val_in;
      la_ff     <= la_in;
      ra_ff     <= ra_in;
      out_pos_ff <= out_pos_in;
      out_x_ff  <= out_x_in;
      out_y_ff  <= out_y_in;
      out_la_ff <= out_la_in;
      out_ra_ff <= out_ra_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign pos_valid    = out_pos_ff;
   assign screen_x     = out_x_ff;
   assign screen_y     = out_y_ff;
   assign left_action  = out_la_ff;
   assign right_action = out_ra_ff;

endmodule

[design/angle_to_cursor_calibrated_mapper_top.sv]
`timescale 1ns / 1ps
// Angle-to-cursor mapper top level: configuration registers, front end,
// job queue and divider back end. Depends on acm_pkg and all acm_ modules.
//
// Maps wand yaw and pitch to a calibrated cursor position, one response per
// request. The front end takes a new request only after it has queued the job
// of the last one; the back end handles one job at a time: load, 24 steps of
// the restoring divider, which runs the x and y quotients side by side, and
// result. A two-entry queue separates the two parts; the response register
// holds a finished result while the next request is taken.

module angle_to_cursor_calibrated_mapper_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // yaw_angle[8:0], pitch_angle[17:9], left_button[18],
                                    // right_button[19], zero fill
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // screen_x[15:0], screen_y[31:16], left_action[33:32],
                                    // right_action[35:34], zero fill
   output logic [0:0]  rsp_tuser,   // pos_valid[0]
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   acm_pkg::cfg_type        cfg_ff;
   acm_pkg::item_type       item;
   acm_pkg::job_type        push_job, pop_job;
   acm_pkg::queue_stat_type q_stat;
   logic q_push, q_pop;
   logic pos_valid;
   logic signed [acm_pkg::POS_W-1:0] screen_x, screen_y;
   acm_pkg::act_type left_action, right_action;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.span_x   <= acm_pkg::SPAN_W'(acm_pkg::SPAN_X_RESET);
         cfg_ff.span_y   <= acm_pkg::SPAN_W'(acm_pkg::SPAN_Y_RESET);
         cfg_ff.margin_x <= acm_pkg::MARGIN_W'(acm_pkg::MARGIN_RESET);
         cfg_ff.margin_y <= acm_pkg::MARGIN_W'(acm_pkg::MARGIN_RESET);
      end else if (csr_we) begin
         case (acm_pkg::csr_index_type'(csr_index))
            acm_pkg::CSR_SPAN_X:   cfg_ff.span_x   <= csr_wdata;
            acm_pkg::CSR_SPAN_Y:   cfg_ff.span_y   <= csr_wdata;
            acm_pkg::CSR_MARGIN_X: cfg_ff.margin_x <= csr_wdata[acm_pkg::MARGIN_W-1:0];
            acm_pkg::CSR_MARGIN_Y: cfg_ff.margin_y <= csr_wdata[acm_pkg::MARGIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign item.kind         = req_tuser;
   assign item.yaw          = req_tdata[8:0];
   assign item.pitch        = $signed(req_tdata[17:9]);
   assign item.left_button  = req_tdata[18];
   assign item.right_button = req_tdata[19];

   acm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .item      (item),
      .cfg       (cfg_ff),
      .qstat     (q_stat),
      .push      (q_push),
      .job       (push_job)
   );

   acm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .qstat    (q_stat)
   );

   acm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .qstat        (q_stat),
      .job          (pop_job),
      .pop          (q_pop),
      .cfg          (cfg_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .pos_valid    (pos_valid),
      .screen_x     (screen_x),
      .screen_y     (screen_y),
      .left_action  (left_action),
      .right_action (right_action)
   );

   assign rsp_tdata = {4'b0000, right_action, left_action, screen_y, screen_x};
   assign rsp_tuser = pos_valid;

`ifndef SYNTH
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("job pushed into full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("job popped from empty queue");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[31:0] == 32'd0))
      else $error("position not zero on invalid response");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("front end ready right after accepting a request");
`endif

endmodule

[sim/angle_to_cursor_calibrated_mapper_top_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the angle-to-cursor mapper: directed and random requests,
// cursor predictions checked response by response. Depends on acm_pkg and the top level.
module angle_to_cursor_calibrated_mapper_top_test;
   import acm_pkg::*;

   localparam int CYCLE_LIMIT      = 500000;
   localparam int DRAIN_SLACK      = 40;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int MAX_REPORTS      = 10;
   localparam int RANDOM_ITEMS     = 100;
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
   localparam logic [13:0] WDATA_ALL_ONES = 14'h3FFF;

   typedef struct {
      logic               pos_valid;
      logic signed [15:0] x;
      logic signed [15:0] y;
      act_type            left_act;
      act_type            right_act;
   } cursor_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [13:0] csr_wdata;

   logic [SPAN_W-1:0]          cfg_span_x, cfg_span_y;
   logic [MARGIN_W-1:0]        cfg_margin_x, cfg_margin_y;
   logic [YAW_W-1:0]           cal_a_yaw, cal_b_yaw, cursor_yaw;
   logic signed [PITCH_W-1:0]  cal_a_pitch, cal_b_pitch, cursor_pitch;
   logic                       cal_a_set, cal_b_set, half_turn_on;
   logic                       left_level, right_level;

   cursor_type pending_cursors[$];
   int      mismatch_count;
   int      accepted_count;
   int      burst_left;
   bit      pacing_on;
   int      long_holds_asked;

   angle_to_cursor_calibrated_mapper_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [YAW_W-1:0] half_turn(logic [YAW_W-1:0] v);
      return YAW_W'((int'(v) + ANG_HALF) % ANG_FULL);
   endfunction

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > POS_MAX) return 16'(POS_MAX);
      if (v < POS_MIN) return 16'(POS_MIN);
      return 16'(v);
   endfunction

   function automatic act_type button_edge(logic now, logic last);
      if (now && !last) return ACT_PRESS;
      if (!now && last) return ACT_RELEASE;
      return ACT_NONE;
   endfunction

   function automatic void recheck_half_turn();
      int d;
      d = int'(cal_a_yaw) - int'(cal_b_yaw);
      if (d < 0) d = -d;
      if (d > ANG_HALF && cal_a_set && cal_b_set) begin
         half_turn_on = 1'b1;
         cal_a_yaw    = half_turn(cal_a_yaw);
         cal_b_yaw    = half_turn(cal_b_yaw);
         cursor_yaw   = half_turn(cursor_yaw);
      end else begin
         half_turn_on = 1'b0;
      end
   endfunction

   function automatic cursor_type place_cursor();
      cursor_type r;
      longint  ex, ey, px, py;
      r.pos_valid = 1'b0;
      r.x         = '0;
      r.y         = '0;
      r.left_act  = ACT_NONE;
      r.right_act = ACT_NONE;
      ex = longint'(cal_b_yaw) - longint'(cal_a_yaw);
      ey = longint'(cal_b_pitch) - longint'(cal_a_pitch);
      if (cal_a_set && cal_b_set && ex != 0 && ey != 0) begin
         px = longint'(cfg_span_x) * (longint'(cursor_yaw) - longint'(cal_a_yaw)) / ex
              + longint'(cfg_margin_x);
         py = longint'(cfg_span_y) * (longint'(cursor_pitch) - longint'(cal_a_pitch)) / ey
              + longint'(cfg_margin_y);
         r.pos_valid = 1'b1;
         r.x         = clamp16(px);
         r.y         = clamp16(py);
      end
      return r;
   endfunction

   function automatic cursor_type map_request(logic [2:0] kind, logic [YAW_W-1:0] yaw_in,
                                              logic signed [PITCH_W-1:0] pitch, logic lb,
                                              logic rb);
      cursor_type       r;
      logic [YAW_W-1:0] yaw;
      r.pos_valid = 1'b0;
      r.x         = '0;
      r.y         = '0;
      r.left_act  = ACT_NONE;
      r.right_act = ACT_NONE;
      yaw = half_turn_on ? half_turn(yaw_in) : yaw_in;
      case (kind)
         KIND_START: begin
            cal_a_set    = 1'b0;
            cal_b_set    = 1'b0;
            half_turn_on = 1'b0;
         end
         KIND_CORNER_A: begin
            cal_a_yaw    = yaw;
            cursor_yaw   = yaw;
            cal_a_pitch  = pitch;
            cursor_pitch = pitch;
            cal_a_set    = 1'b1;
            recheck_half_turn();
            r = place_cursor();
         end
         KIND_CORNER_B: begin
            cal_b_yaw    = yaw;
            cursor_yaw   = yaw;
            cal_b_pitch  = pitch;
            cursor_pitch = pitch;
            cal_b_set    = 1'b1;
            recheck_half_turn();
            r = place_cursor();
         end
         KIND_MOVE: begin
            cursor_yaw   = yaw;
            cursor_pitch = pitch;
            r = place_cursor();
            r.left_act  = button_edge(lb, left_level);
            r.right_act = button_edge(rb, right_level);
            left_level  = lb;
            right_level = rb;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   function automatic void reset_model();
      cfg_span_x   = SPAN_W'(SPAN_X_RESET);
      cfg_span_y   = SPAN_W'(SPAN_Y_RESET);
      cfg_margin_x = MARGIN_W'(MARGIN_RESET);
      cfg_margin_y = MARGIN_W'(MARGIN_RESET);
      cal_a_yaw    = '0;
      cal_b_yaw    = '0;
      cursor_yaw   = '0;
      cal_a_pitch  = '0;
      cal_b_pitch  = '0;
      cursor_pitch = '0;
      cal_a_set    = 1'b0;
      cal_b_set    = 1'b0;
      half_turn_on = 1'b0;
      left_level   = 1'b0;
      right_level  = 1'b0;
   endfunction

   function automatic logic [YAW_W-1:0] rand_yaw();
      if ($urandom_range(0, 9) == 0) return YAW_W'($urandom_range(0, 511));
      return YAW_W'($urandom_range(0, ANG_FULL - 1));
   endfunction

   function automatic logic signed [PITCH_W-1:0] rand_pitch();
      if ($urandom_range(0, 9) == 0) return PITCH_W'($urandom_range(0, 511));
      return PITCH_W'(int'($urandom_range(0, ANG_FULL)) - ANG_HALF);
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic send_request(logic [2:0] kind, logic [YAW_W-1:0] yaw,
                               logic signed [PITCH_W-1:0] pitch, logic lb, logic rb);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, rb, lb, pitch, yaw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_cursors.push_back(map_request(kind, yaw, pitch, lb, rb));
      if (kind <= KIND_END) accepted_count++;
      if (pacing_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 24);
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_cursors.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [13:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_SPAN_X:   cfg_span_x   = value;
         CSR_SPAN_Y:   cfg_span_y   = value;
         CSR_MARGIN_X: cfg_margin_x = value[MARGIN_W-1:0];
         CSR_MARGIN_Y: cfg_margin_y = value[MARGIN_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic apply_settings(logic [13:0] sx, logic [13:0] sy, logic [13:0] mx,
                                 logic [13:0] my);
      drain_results();
      write_register(CSR_SPAN_X, sx);
      write_register(CSR_SPAN_Y, sy);
      write_register(CSR_MARGIN_X, mx);
      write_register(CSR_MARGIN_Y, my);
      csr_we <= 1'b0;
   endtask

   task automatic test_idle_buttons();
      send_request(KIND_MOVE, 9'd0, 9'sd0, 1'b1, 1'b0);
      send_request(KIND_MOVE, 9'd359, 9'sd180, 1'b1, 1'b1);
      send_request(KIND_MOVE, 9'd0, -9'sd180, 1'b0, 1'b0);
      for (int k = int'(KIND_UNUSED_LO); k <= int'(KIND_UNUSED_HI); k++)
         send_request(3'(k), 9'd511, -9'sd256, 1'b1, 1'b1);
      send_request(KIND_END, 9'd200, 9'sd45, 1'b1, 1'b1);
   endtask

   task automatic test_basic_mapping();
      send_request(KIND_START, 9'd0, 9'sd0, 1'b0, 1'b0);
      send_request(KIND_CORNER_A, 9'd100, 9'sd60, 1'b0, 1'b0);
      send_request(KIND_CORNER_B, 9'd200, -9'sd60, 1'b0, 1'b0);
      send_request(KIND_MOVE, 9'd150, 9'sd0, 1'b1, 1'b0);
      send_request(KIND_MOVE, 9'd511, -9'sd256, 1'b0, 1'b1);
      send_request(KIND_MOVE, 9'd255, 9'sd255, 1'b0, 1'b0);
   endtask

   task automatic test_yaw_wrap();
      send_request(KIND_START, 9'd0, 9'sd0, 1'b0, 1'b0);
      send_request(KIND_CORNER_A, 9'd350, 9'sd10, 1'b0, 1'b0);
      send_request(KIND_CORNER_B, 9'd10, 9'sd100, 1'b0, 1'b0);
      send_request(KIND_MOVE, 9'd0, 9'sd50, 1'b0, 1'b0);
      send_request(KIND_MOVE, 9'd400, 9'sd20, 1'b0, 1'b0);
      send_request(KIND_CORNER_B, 9'd30, 9'sd90, 1'b0, 1'b0);
      send_request(KIND_CORNER_A, 9'd300, 9'sd0, 1'b0, 1'b0);
   endtask

   task automatic test_zero_extent();
      send_request(KIND_START, 9'd0, 9'sd0, 1'b0, 1'b0);
      send_request(KIND_CORNER_A, 9'd90, 9'sd30, 1'b0, 1'b0);
      send_request(KIND_CORNER_B, 9'd90, -9'sd30, 1'b0, 1'b0);
      send_request(KIND_CORNER_B, 9'd120, 9'sd30, 1'b0, 1'b0);
      send_request(KIND_MOVE, 9'd100, 9'sd10, 1'b0, 1'b0);
   endtask

   task automatic test_register_extremes();
      apply_settings(WDATA_ALL_ONES, WDATA_ALL_ONES, WDATA_ALL_ONES, WDATA_ALL_ONES);
      send_request(KIND_START, 9'd0, 9'sd0, 1'b0, 1'b0);
      send_request(KIND_CORNER_A, 9'd300, 9'sd0, 1'b0, 1'b0);
      send_request(KIND_CORNER_B, 9'd301, 9'sd1, 1'b0, 1'b0);
      send_request(KIND_MOVE, 9'd0, -9'sd256, 1'b0, 1'b0);
      send_request(KIND_MOVE, 9'd511, 9'sd255, 1'b0, 1'b0);
      apply_settings(14'd0, 14'd0, 14'd0, 14'd0);
      send_request(KIND_MOVE, 9'd150, -9'sd100, 1'b0, 1'b0);
   endtask

   task automatic test_backpressure();
      apply_settings(14'(SPAN_X_RESET), 14'(SPAN_Y_RESET), 14'(MARGIN_RESET),
                     14'(MARGIN_RESET));
      pacing_on = 1'b0;
      long_holds_asked++;
      send_request(KIND_START, 9'd0, 9'sd0, 1'b0, 1'b0);
      send_request(KIND_CORNER_A, 9'd20, -9'sd40, 1'b0, 1'b0);
      send_request(KIND_CORNER_B, 9'd140, 9'sd40, 1'b0, 1'b0);
      repeat (9) send_request(KIND_MOVE, rand_yaw(), rand_pitch(), rand_bit(), rand_bit());
      drain_results();
      pacing_on = 1'b1;
   endtask

   task automatic run_sessions(int n_items);
      int                        goal;
      logic [YAW_W-1:0]          ya, yb;
      logic signed [PITCH_W-1:0] pa, pb;
      goal = accepted_count + n_items;
      while (accepted_count < goal) begin
         pacing_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 7) != 0) begin
            ya = rand_yaw();
            yb = ($urandom_range(0, 9) == 0) ? ya : rand_yaw();
            pa = rand_pitch();
            pb = ($urandom_range(0, 9) == 0) ? pa : rand_pitch();
            send_request(KIND_START, rand_yaw(), rand_pitch(), rand_bit(), rand_bit());
            if ($urandom_range(0, 4) == 0) begin
               send_request(KIND_CORNER_B, yb, pb, rand_bit(), rand_bit());
               send_request(KIND_CORNER_A, ya, pa, rand_bit(), rand_bit());
            end else begin
               send_request(KIND_CORNER_A, ya, pa, rand_bit(), rand_bit());
               send_request(KIND_CORNER_B, yb, pb, rand_bit(), rand_bit());
            end
            repeat ($urandom_range(2, 14)) begin
               if ($urandom_range(0, 11) == 0)
                  send_request(3'($urandom_range(int'(KIND_CORNER_A), int'(KIND_CORNER_B))),
                               rand_yaw(), rand_pitch(), rand_bit(), rand_bit());
               else
                  send_request(KIND_MOVE, rand_yaw(), rand_pitch(), rand_bit(), rand_bit());
            end
            if (rand_bit()) send_request(KIND_END, rand_yaw(), rand_pitch(), rand_bit(), rand_bit());
         end else begin
            repeat ($urandom_range(1, 4))
               send_request(3'($urandom_range(0, 7)), YAW_W'($urandom_range(0, 511)),
                            PITCH_W'($urandom_range(0, 511)), rand_bit(), rand_bit());
         end
      end
   endtask

   task automatic test_random_sessions();
      run_sessions(RANDOM_ITEMS);
      apply_settings(14'd1, 14'd1, 14'd0, 14'd0);
      run_sessions(RANDOM_ITEMS);
      apply_settings(14'd8192, 14'd8192, 14'd4095, 14'd4095);
      run_sessions(RANDOM_ITEMS);
      apply_settings(14'($urandom_range(1, 8192)), 14'($urandom_range(1, 8192)),
                     14'($urandom_range(0, 4095)), 14'($urandom_range(0, 4095)));
      run_sessions(RANDOM_ITEMS);
   endtask

   initial begin : rsp_ready_pattern
      int mode, mode_left, hold_left, holds_done;
      mode       = 0;
      mode_left  = 0;
      hold_left  = 0;
      holds_done = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != long_holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 160);
            end else begin
               mode_left--;
            end
            case (mode)
               0, 1:    rsp_tready <= 1'b1;
               2:       rsp_tready <= rand_bit();
               default: rsp_tready <= ($urandom_range(0, 5) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_responses
      cursor_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_cursors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected response: tuser %h tdata %h", rsp_tuser, rsp_tdata);
         end else begin
            want = pending_cursors.pop_front();
            if (rsp_tuser[0] !== want.pos_valid || rsp_tdata[15:0] !== want.x ||
                rsp_tdata[31:16] !== want.y || rsp_tdata[33:32] !== want.left_act ||
                rsp_tdata[35:34] !== want.right_act) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch: expected valid %0d x %0d y %0d left %0d right %0d, %s",
                           want.pos_valid, want.x, want.y, want.left_act, want.right_act,
                           $sformatf("got valid %0d x %0d y %0d left %0d right %0d",
                                     rsp_tuser[0], $signed(rsp_tdata[15:0]),
                                     $signed(rsp_tdata[31:16]), rsp_tdata[33:32],
                                     rsp_tdata[35:34]));
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_SPAN_X;
      csr_wdata  <= '0;
      mismatch_count   = 0;
      accepted_count   = 0;
      burst_left       = 0;
      pacing_on        = 1'b1;
      long_holds_asked = 0;
      reset_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_idle_buttons();
      test_basic_mapping();
      test_yaw_wrap();
      test_zero_extent();
      test_register_extremes();
      test_backpressure();
      test_random_sessions();
      drain_results();
      if (mismatch_count == 0 && pending_cursors.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
